@@ hw/rtl/msgseg_pkg.sv @@
// msgseg_pkg: shared types and constants of the message segmenter
package msgseg_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_FRAG = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] REG_SINGLE_LIMIT = 2'd0;
  localparam logic [1:0] REG_START_FRAG = 2'd1;
  localparam logic [1:0] REG_FRAG = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] msg_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  pkt_kind;
    logic [7:0]  message_id;
    logic [15:0] seq_number;
    logic [31:0] out_src;
    logic [31:0] out_dst;
    logic [31:0] total_size;
    logic [31:0] payload_offset;
    logic [31:0] payload_bytes;
    logic        last_packet;
  } pkt_t;

  typedef struct packed {
    logic [15:0] single_limit;
    logic [15:0] start_frag_bytes;
    logic [15:0] frag_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] msg_size;
    logic [31:0] rest;
  } cmd_t;

endpackage

@@ hw/rtl/msgseg_front.sv @@
// msgseg_front: accepts requests and classifies them into commands
module msgseg_front #(
  parameter int unsigned MAX_PACKETS = 64
) (
  input  logic               req_valid,
  output logic               req_stall,
  input  msgseg_pkg::req_t   req,
  input  msgseg_pkg::cfg_t   cfg,
  input  logic               q_full,
  output logic               q_push,
  output msgseg_pkg::cmd_t   q_cmd
);

  localparam int unsigned CntW = $clog2(MAX_PACKETS);
  localparam logic [CntW-1:0] MidMax = CntW'(MAX_PACKETS - 1);

  logic [CntW+15:0] mid_limit;
  logic [31:0]      rest;
  logic             is_single;
  logic             is_error;

  assign mid_limit = {{CntW{1'b0}}, cfg.frag_bytes} * {16'd0, MidMax};
  assign rest = req.msg_size - {16'd0, cfg.start_frag_bytes};
  assign is_single = req.msg_size <= {16'd0, cfg.single_limit};
  assign is_error = (req.msg_size <= {16'd0, cfg.start_frag_bytes}) ||
                    (cfg.frag_bytes == 16'd0) ||
                    (rest > 32'(mid_limit));

  assign req_stall = q_full;
  assign q_push = req_valid && !q_full;

  always_comb begin
    q_cmd.src_addr = req.src_addr;
    q_cmd.dst_addr = req.dst_addr;
    q_cmd.msg_size = req.msg_size;
    q_cmd.rest = rest;
    if (is_single) begin
      q_cmd.kind = msgseg_pkg::KIND_SINGLE;
    end else if (is_error) begin
      q_cmd.kind = msgseg_pkg::KIND_ERROR;
    end else begin
      q_cmd.kind = msgseg_pkg::KIND_START;
    end
  end

endmodule

@@ hw/rtl/msgseg_queue.sv @@
// msgseg_queue: short command queue between front and back
module msgseg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msgseg_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output msgseg_pkg::cmd_t head
);

  msgseg_pkg::cmd_t                      entries [msgseg_pkg::QueueDepth];
  logic [msgseg_pkg::QueuePtrW-1:0]      wr_ptr;
  logic [msgseg_pkg::QueuePtrW-1:0]      rd_ptr;
  logic [msgseg_pkg::QueueCntW-1:0]      count;

  assign full = count == msgseg_pkg::QueueCntW'(msgseg_pkg::QueueDepth);
  assign not_empty = count != '0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == msgseg_pkg::QueuePtrW'(msgseg_pkg::QueueDepth - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == msgseg_pkg::QueuePtrW'(msgseg_pkg::QueueDepth - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/msgseg_back.sv @@
// msgseg_back: packet sequencer with id and sequence counters
module msgseg_back (
  input  logic             clk,
  input  logic             rst,
  input  msgseg_pkg::cfg_t cfg,
  input  logic             q_valid,
  input  msgseg_pkg::cmd_t q_cmd,
  output logic             q_pop,
  output logic             pkt_valid,
  input  logic             pkt_stall,
  output msgseg_pkg::pkt_t pkt
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [7:0]       message_counter;
  logic [7:0]       message_counter_next;
  logic [15:0]      sequence_counter;
  logic [15:0]      sequence_counter_next;
  logic [31:0]      bytes_remaining;
  logic [31:0]      bytes_remaining_next;
  logic [31:0]      current_offset;
  logic [31:0]      current_offset_next;
  logic             pkt_valid_next;
  msgseg_pkg::pkt_t pkt_next;

  logic        load;
  logic [32:0] diff;
  logic        more;
  logic [7:0]  id_inc;
  logic [15:0] seq_inc;

  assign load = !pkt_valid || !pkt_stall;
  assign diff = {1'b0, bytes_remaining} - {17'd0, cfg.frag_bytes};
  assign more = !diff[32] && (diff[31:0] != 32'd0);
  assign id_inc = message_counter + 8'd1;
  assign seq_inc = sequence_counter + 16'd1;

  always_comb begin
    state_next = state;
    message_counter_next = message_counter;
    sequence_counter_next = sequence_counter;
    bytes_remaining_next = bytes_remaining;
    current_offset_next = current_offset;
    pkt_valid_next = pkt_valid;
    pkt_next = pkt;
    q_pop = 1'b0;
    if (load) begin
      pkt_valid_next = 1'b0;
    end
    unique case (state)
      ST_IDLE: begin
        if (load && q_valid) begin
          q_pop = 1'b1;
          pkt_valid_next = 1'b1;
          pkt_next = '0;
          case (q_cmd.kind)
            msgseg_pkg::KIND_SINGLE: begin
              message_counter_next = id_inc;
              sequence_counter_next = seq_inc;
              pkt_next.pkt_kind = msgseg_pkg::KIND_SINGLE;
              pkt_next.message_id = id_inc;
              pkt_next.seq_number = seq_inc;
              pkt_next.out_src = q_cmd.src_addr;
              pkt_next.out_dst = q_cmd.dst_addr;
              pkt_next.total_size = q_cmd.msg_size;
              pkt_next.payload_bytes = q_cmd.msg_size;
              pkt_next.last_packet = 1'b1;
            end
            msgseg_pkg::KIND_START: begin
              message_counter_next = id_inc;
              sequence_counter_next = seq_inc;
              bytes_remaining_next = q_cmd.rest;
              current_offset_next = {16'd0, cfg.start_frag_bytes};
              state_next = ST_RUN;
              pkt_next.pkt_kind = msgseg_pkg::KIND_START;
              pkt_next.message_id = id_inc;
              pkt_next.seq_number = seq_inc;
              pkt_next.out_src = q_cmd.src_addr;
              pkt_next.out_dst = q_cmd.dst_addr;
              pkt_next.total_size = q_cmd.msg_size;
              pkt_next.payload_bytes = {16'd0, cfg.start_frag_bytes};
            end
            default: begin
              pkt_next.pkt_kind = msgseg_pkg::KIND_ERROR;
              pkt_next.last_packet = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (load) begin
          pkt_valid_next = 1'b1;
          sequence_counter_next = seq_inc;
          pkt_next = '0;
          pkt_next.pkt_kind = msgseg_pkg::KIND_FRAG;
          pkt_next.message_id = message_counter;
          pkt_next.seq_number = seq_inc;
          pkt_next.payload_offset = current_offset;
          if (more) begin
            pkt_next.payload_bytes = {16'd0, cfg.frag_bytes};
            current_offset_next = current_offset + {16'd0, cfg.frag_bytes};
            bytes_remaining_next = diff[31:0];
          end else begin
            pkt_next.payload_bytes = bytes_remaining;
            pkt_next.last_packet = 1'b1;
            current_offset_next = current_offset + bytes_remaining;
            bytes_remaining_next = 32'd0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pkt <= pkt_next;
    bytes_remaining <= bytes_remaining_next;
    current_offset <= current_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      message_counter <= 8'd0;
      sequence_counter <= 16'hffff;
      pkt_valid <= 1'b0;
    end else begin
      state <= state_next;
      message_counter <= message_counter_next;
      sequence_counter <= sequence_counter_next;
      pkt_valid <= pkt_valid_next;
    end
  end

endmodule

@@ hw/rtl/message_segmenter.sv @@
// message_segmenter: top level with configuration registers
// the first packet of a request passes through the command queue and then the packet register
// throughput: single and error requests one per cycle while pkt_stall is low; a fragmented
//   request holds the back sequencer, one packet per unstalled cycle (2 to MAX_PACKETS)
// the front takes new requests while the two-entry command queue has room
// reset: synchronous; message id 0, sequence number all ones, queue empty
module message_segmenter #(
  parameter int unsigned MAX_PACKETS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [msgseg_pkg::CfgAddrW-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  msgseg_pkg::req_t                    req,
  output logic                                pkt_valid,
  input  logic                                pkt_stall,
  output msgseg_pkg::pkt_t                    pkt
);

  msgseg_pkg::cfg_t cfg;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  msgseg_pkg::cmd_t push_cmd;
  msgseg_pkg::cmd_t head_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_limit <= 16'd0;
      cfg.start_frag_bytes <= 16'd1;
      cfg.frag_bytes <= 16'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        msgseg_pkg::REG_SINGLE_LIMIT: cfg.single_limit <= pwdata[15:0];
        msgseg_pkg::REG_START_FRAG:   cfg.start_frag_bytes <= pwdata[15:0];
        msgseg_pkg::REG_FRAG:         cfg.frag_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      msgseg_pkg::REG_SINGLE_LIMIT: prdata = {16'd0, cfg.single_limit};
      msgseg_pkg::REG_START_FRAG:   prdata = {16'd0, cfg.start_frag_bytes};
      msgseg_pkg::REG_FRAG:         prdata = {16'd0, cfg.frag_bytes};
      default:                      prdata = 32'd0;
    endcase
  end

  msgseg_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .cfg(cfg),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(push_cmd)
  );

  msgseg_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .head(head_cmd)
  );

  msgseg_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_cmd(head_cmd),
    .q_pop(q_pop),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt(pkt)
  );

endmodule

@@ test/tb.sv @@
// tb: self-checking testbench for the message segmenter with random traffic and stalls
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxPackets = 64;
  localparam int unsigned CycleLimit = 2000000;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [msgseg_pkg::CfgAddrW-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;
  logic                            req_valid;
  logic                            req_stall;
  msgseg_pkg::req_t                req;
  logic                            pkt_valid;
  logic                            pkt_stall;
  msgseg_pkg::pkt_t                pkt;

  // settings and counters as the segmenter should hold them
  logic [15:0] cfg_single_limit;
  logic [15:0] cfg_start_frag;
  logic [15:0] cfg_frag;
  logic [7:0]  model_msg_id;
  logic [15:0] model_seq;

  msgseg_pkg::pkt_t expected_pkts[$];
  msgseg_pkg::pkt_t want_pkt;
  int unsigned      packets_checked;
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  int unsigned      stall_left;

  message_segmenter #(
    .MAX_PACKETS(MaxPackets)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt      (pkt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp) begin
      report_mismatch($sformatf("packet %0d %s got %h expected %h",
                                packets_checked, name, got, exp));
    end
  endtask

  function automatic void push_packet(input logic [1:0] kind, input msgseg_pkg::req_t r,
                                      input logic [31:0] offset,
                                      input logic [31:0] nbytes, input logic last);
    msgseg_pkg::pkt_t p;
    p = '0;
    p.pkt_kind = kind;
    p.last_packet = last;
    if (kind != msgseg_pkg::KIND_ERROR) begin
      model_seq = model_seq + 16'd1;
      p.message_id = model_msg_id;
      p.seq_number = model_seq;
      p.payload_offset = offset;
      p.payload_bytes = nbytes;
    end
    if (kind == msgseg_pkg::KIND_SINGLE || kind == msgseg_pkg::KIND_START) begin
      p.out_src = r.src_addr;
      p.out_dst = r.dst_addr;
      p.total_size = r.msg_size;
    end
    expected_pkts.push_back(p);
  endfunction

  // splits one accepted request into the packets it should produce
  function automatic void segment_message(input msgseg_pkg::req_t r);
    logic [31:0] rest;
    logic [31:0] offset;
    logic [31:0] left;
    longint unsigned npk;
    if (r.msg_size <= {16'h0, cfg_single_limit}) begin
      model_msg_id = model_msg_id + 8'd1;
      push_packet(msgseg_pkg::KIND_SINGLE, r, 32'd0, r.msg_size, 1'b1);
    end else if (r.msg_size <= {16'h0, cfg_start_frag} || cfg_frag == 16'd0) begin
      push_packet(msgseg_pkg::KIND_ERROR, r, 32'd0, 32'd0, 1'b1);
    end else begin
      rest = r.msg_size - {16'h0, cfg_start_frag};
      npk = 64'd2 + 64'((rest - 32'd1) / {16'h0, cfg_frag});
      if (npk > MaxPackets) begin
        push_packet(msgseg_pkg::KIND_ERROR, r, 32'd0, 32'd0, 1'b1);
      end else begin
        model_msg_id = model_msg_id + 8'd1;
        push_packet(msgseg_pkg::KIND_START, r, 32'd0, {16'h0, cfg_start_frag}, 1'b0);
        offset = {16'h0, cfg_start_frag};
        left = rest;
        while (left > {16'h0, cfg_frag}) begin
          push_packet(msgseg_pkg::KIND_FRAG, r, offset, {16'h0, cfg_frag}, 1'b0);
          offset = offset + {16'h0, cfg_frag};
          left = left - {16'h0, cfg_frag};
        end
        push_packet(msgseg_pkg::KIND_FRAG, r, offset, left, 1'b1);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && pkt_valid && !pkt_stall) begin
      if (expected_pkts.size() == 0) begin
        report_mismatch($sformatf("unexpected packet kind %0d id %0d seq %0d",
                                  pkt.pkt_kind, pkt.message_id, pkt.seq_number));
      end else begin
        want_pkt = expected_pkts.pop_front();
        check_field("pkt_kind", 32'(pkt.pkt_kind), 32'(want_pkt.pkt_kind));
        check_field("message_id", 32'(pkt.message_id), 32'(want_pkt.message_id));
        check_field("seq_number", 32'(pkt.seq_number), 32'(want_pkt.seq_number));
        check_field("out_src", pkt.out_src, want_pkt.out_src);
        check_field("out_dst", pkt.out_dst, want_pkt.out_dst);
        check_field("total_size", pkt.total_size, want_pkt.total_size);
        check_field("payload_offset", pkt.payload_offset, want_pkt.payload_offset);
        check_field("payload_bytes", pkt.payload_bytes, want_pkt.payload_bytes);
        check_field("last_packet", 32'(pkt.last_packet), 32'(want_pkt.last_packet));
      end
      packets_checked++;
    end
  end

  // receiver: stall runs with long open stretches between them
  always @(negedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        pkt_stall <= 1'b1;
        stall_left = $urandom_range(1, 4);
      end else begin
        pkt_stall <= 1'b0;
        stall_left = $urandom_range(1, 40);
      end
    end else begin
      stall_left--;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [31:0] src, input logic [31:0] dst,
                              input logic [31:0] size);
    msgseg_pkg::req_t r;
    r.src_addr = src;
    r.dst_addr = dst;
    r.msg_size = size;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    segment_message(r);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_pkts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0, value}) begin
      report_mismatch($sformatf("register %0d read %h expected %h", idx, prdata,
                                {16'h0, value}));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      msgseg_pkg::REG_SINGLE_LIMIT: cfg_single_limit = value;
      msgseg_pkg::REG_START_FRAG:   cfg_start_frag = value;
      msgseg_pkg::REG_FRAG:         cfg_frag = value;
      default:                      ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] limit, input logic [15:0] start,
                            input logic [15:0] frag);
    wait_idle();
    write_register(msgseg_pkg::REG_SINGLE_LIMIT, limit);
    write_register(msgseg_pkg::REG_START_FRAG, start);
    write_register(msgseg_pkg::REG_FRAG, frag);
  endtask

  function automatic logic [31:0] pick_msg_size();
    int unsigned sel;
    int unsigned npk;
    logic [31:0] fb;
    logic [31:0] size;
    sel = $urandom_range(0, 99);
    fb = (cfg_frag == 16'd0) ? 32'd1 : {16'h0, cfg_frag};
    if (sel < 25) begin
      size = $urandom_range(0, cfg_single_limit);
    end else if (sel < 78) begin
      npk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, MaxPackets)
                                        : $urandom_range(2, 8);
      size = {16'h0, cfg_start_frag} + (npk - 2) * fb + $urandom_range(1, fb);
    end else if (sel < 90) begin
      case ($urandom_range(0, 5))
        0:       size = {16'h0, cfg_single_limit};
        1:       size = {16'h0, cfg_single_limit} + 32'd1;
        2:       size = {16'h0, cfg_start_frag};
        3:       size = {16'h0, cfg_start_frag} + 32'd1;
        4:       size = {16'h0, cfg_start_frag} + (MaxPackets - 1) * fb;
        default: size = {16'h0, cfg_start_frag} + (MaxPackets - 1) * fb + 32'd1;
      endcase
    end else begin
      size = $urandom;
    end
    return size;
  endfunction

  task automatic test_reset_settings();
    send_request(32'h0, 32'h0, 32'd0);
    send_request(32'hffff_ffff, 32'hffff_ffff, 32'd0);
    send_request($urandom, $urandom, 32'd1);
    send_request($urandom, $urandom, 32'd2);
    send_request($urandom, $urandom, 32'd64);
    send_request($urandom, $urandom, 32'd65);
    send_request($urandom, $urandom, 32'hffff_ffff);
  endtask

  task automatic test_extreme_settings();
    set_config(16'hffff, 16'hffff, 16'hffff);
    send_request($urandom, $urandom, 32'd65535);
    send_request($urandom, $urandom, 32'd65536);
    send_request($urandom, $urandom, 32'd65535 * 64);
    send_request($urandom, $urandom, 32'd65535 * 64 + 1);
    send_request($urandom, $urandom, 32'hffff_ffff);
    // a zero fragment size turns every request above the single limit into an error
    set_config(16'hffff, 16'hffff, 16'h0);
    send_request($urandom, $urandom, 32'd65536);
    send_request($urandom, $urandom, 32'd65535);
  endtask

  task automatic test_zero_start();
    set_config(16'h0, 16'h0, 16'd7);
    send_request($urandom, $urandom, 32'd1);
    send_request($urandom, $urandom, 32'd15);
    send_request($urandom, $urandom, 32'd7 * 64);
    send_request($urandom, $urandom, 32'd7 * 64 + 1);
  endtask

  task automatic test_short_after_start();
    set_config(16'd10, 16'd20, 16'd5);
    send_request($urandom, $urandom, 32'd15);
    send_request($urandom, $urandom, 32'd20);
    send_request($urandom, $urandom, 32'd21);
    send_request($urandom, $urandom, 32'd10);
  endtask

  task automatic random_phase(input logic [15:0] limit, input logic [15:0] start,
                              input logic [15:0] frag, input int unsigned count);
    set_config(limit, start, frag);
    repeat (count) send_request($urandom, $urandom, pick_msg_size());
  endtask

  task automatic test_random_traffic();
    random_phase(16'd100, 16'd64, 16'd32, 65);
    random_phase(16'd0, 16'd1, 16'd1, 65);
    random_phase(16'hffff, 16'hffff, 16'hffff, 65);
    random_phase(16'($urandom_range(0, 2000)), 16'($urandom_range(1, 1500)),
                 16'($urandom_range(1, 400)), 65);
    random_phase(16'($urandom_range(0, 300)), 16'h0, 16'($urandom_range(1, 100)), 65);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req = '0;
    burst_left = 0;
    cfg_single_limit = 16'h0;
    cfg_start_frag = 16'd1;
    cfg_frag = 16'd1;
    model_msg_id = 8'h0;
    model_seq = 16'hffff;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_settings();
    test_extreme_settings();
    test_zero_start();
    test_short_after_start();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_pkts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
